/* src/fwrm_pkg.sv */
// ----------------------------------------------------------------------------
// fwrm_pkg: shared definitions for the running-minimum fifo
// Widths, command and status codes, and the structs that pass between the
// top level and the storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fwrm_pkg;

	// queue geometry
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths
	localparam int CMD_W   = 3;
	localparam int VAL_W   = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// command codes; unlisted codes behave as min
	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE = 3'd0,
		CMD_DEQUEUE = 3'd1,
		CMD_FRONT   = 3'd2,
		CMD_MIN     = 3'd3,
		CMD_SIZE    = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic                    enq;
		logic                    deq;
		logic                    clr;
		logic signed [VAL_W-1:0] x;
	} cell_ctrl_t;

	// contents of one cell as seen by its neighbor
	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] smin;
	} cell_data_t;

endpackage

`default_nettype wire

/* src/fwrm_req_if.sv */
// ----------------------------------------------------------------------------
// fwrm_req_if: command channel
// Valid/ready channel carrying one command and its operand per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwrm_req_if;

	logic                                  valid;
	logic                                  ready;
	logic [fwrm_pkg::CMD_W-1:0]            cmd;
	logic signed [fwrm_pkg::VAL_W-1:0]     value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);

endinterface

`default_nettype wire

/* src/fwrm_rsp_if.sv */
// ----------------------------------------------------------------------------
// fwrm_rsp_if: result channel
// Valid/ready channel carrying status, data and count per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwrm_rsp_if;

	logic                                  valid;
	logic                                  ready;
	logic [fwrm_pkg::STAT_W-1:0]           status;
	logic signed [fwrm_pkg::VAL_W-1:0]     data;
	logic [fwrm_pkg::COUNT_W-1:0]          count;

	modport source (output valid, status, data, count, input ready);
	modport sink   (input valid, status, data, count, output ready);

endinterface

`default_nettype wire

/* src/fwrm_cell.sv */
// ----------------------------------------------------------------------------
// fwrm_cell: one queue position
// Holds a value and the minimum from this entry to the newest. Takes a new
// value when it is the first free position, lowers its minimum when an
// enqueue brings a smaller value, and loads its upper neighbor on a dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrm_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fwrm_pkg::cell_ctrl_t ctrl,
	input  wire logic                 prev_valid,
	input  wire fwrm_pkg::cell_data_t next_data,
	output fwrm_pkg::cell_data_t      data
);

	logic                              valid_q;
	logic signed [fwrm_pkg::VAL_W-1:0] value_q;
	logic signed [fwrm_pkg::VAL_W-1:0] smin_q;
	logic                              first_free;
	logic                              x_lower;

	// this cell is the next slot to fill
	assign first_free = prev_valid && !valid_q;
	assign x_lower    = ctrl.x < smin_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.deq) begin
			valid_q <= next_data.valid;
		end else if (ctrl.enq && first_free) begin
			valid_q <= 1'b1;
		end
	end

	// value and suffix minimum
	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			value_q <= next_data.value;
			smin_q  <= next_data.smin;
		end else if (ctrl.enq) begin
			if (first_free) begin
				value_q <= ctrl.x;
				smin_q  <= ctrl.x;
			end else if (valid_q && x_lower) begin
				smin_q <= ctrl.x;
			end
		end
	end

	assign data.valid = valid_q;
	assign data.value = value_q;
	assign data.smin  = smin_q;

endmodule

`default_nettype wire

/* src/fifo_with_running_minimum.sv */
// ----------------------------------------------------------------------------
// fifo_with_running_minimum: bounded fifo reporting the minimum it holds
// A chain of cells keeps each entry with its suffix minimum, oldest at
// cell zero, so front and min are read from cell zero directly.
// ----------------------------------------------------------------------------
// result: registered at the command transfer
// throughput: one command per cycle while the result register is free; every cell updates in parallel
// the only stall is a result register that the sink has not yet taken
// reset: clears the cell valid bits, the held count and the result valid;
// entry payloads are not reset and are never read before being written
`default_nettype none

module fifo_with_running_minimum (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fwrm_req_if.sink      req,
	fwrm_rsp_if.source    rsp
);

	localparam int DEPTH = fwrm_pkg::DEPTH;

	logic [fwrm_pkg::CNT_W-1:0]          held_q;
	logic [fwrm_pkg::CNT_W-1:0]          held_nxt;
	logic                                rsp_valid_q;
	logic [fwrm_pkg::STAT_W-1:0]         rsp_status_q;
	logic signed [fwrm_pkg::VAL_W-1:0]   rsp_data_q;
	logic [fwrm_pkg::COUNT_W-1:0]        rsp_count_q;

	logic                                xfer;
	logic                                empty;
	logic                                full;
	fwrm_pkg::cmd_t                      cmd;
	fwrm_pkg::status_t                   status_nxt;
	logic signed [fwrm_pkg::VAL_W-1:0]   data_nxt;
	fwrm_pkg::cell_ctrl_t                ctrl;
	fwrm_pkg::cell_data_t                cell_data [DEPTH];
	logic [DEPTH-1:0]                    valid_vec;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;
	assign cmd       = fwrm_pkg::cmd_t'(req.cmd);
	assign empty     = held_q == '0;
	assign full      = held_q == fwrm_pkg::CNT_W'(DEPTH);

	// cell control
	always_comb begin
		ctrl.x   = req.value;
		ctrl.enq = xfer && cmd == fwrm_pkg::CMD_ENQUEUE && !full;
		ctrl.deq = xfer && cmd == fwrm_pkg::CMD_DEQUEUE && !empty;
		ctrl.clr = xfer && cmd == fwrm_pkg::CMD_CLEAR;
	end

	// result and next count
	always_comb begin
		status_nxt = fwrm_pkg::ST_OK;
		data_nxt   = '0;
		held_nxt   = held_q;
		case (cmd)
			fwrm_pkg::CMD_ENQUEUE: begin
				if (full) begin
					status_nxt = fwrm_pkg::ST_FULL;
				end else begin
					held_nxt = held_q + fwrm_pkg::CNT_W'(1);
				end
			end
			fwrm_pkg::CMD_SIZE: begin
				status_nxt = fwrm_pkg::ST_OK;
			end
			fwrm_pkg::CMD_CLEAR: begin
				held_nxt = '0;
			end
			fwrm_pkg::CMD_DEQUEUE: begin
				if (empty) begin
					status_nxt = fwrm_pkg::ST_EMPTY;
				end else begin
					data_nxt = cell_data[0].value;
					held_nxt = held_q - fwrm_pkg::CNT_W'(1);
				end
			end
			fwrm_pkg::CMD_FRONT: begin
				if (empty) begin
					status_nxt = fwrm_pkg::ST_EMPTY;
				end else begin
					data_nxt = cell_data[0].value;
				end
			end
			default: begin
				// min, and any unused code
				if (empty) begin
					status_nxt = fwrm_pkg::ST_EMPTY;
				end else begin
					data_nxt = cell_data[0].smin;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				held_q <= held_nxt;
			end
			if (xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_status_q <= status_nxt;
			rsp_data_q   <= data_nxt;
			rsp_count_q  <= fwrm_pkg::COUNT_W'(held_nxt);
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.count  = rsp_count_q;

	// cell chain, oldest entry at cell zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 prev_valid;
		fwrm_pkg::cell_data_t next_data;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = cell_data[i-1].valid;
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_data = '0;
		end else begin : g_link
			assign next_data = cell_data[i+1];
		end

		fwrm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_valid),
			.next_data  (next_data),
			.data       (cell_data[i])
		);

		assign valid_vec[i] = cell_data[i].valid;
	end

	// count never exceeds the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= fwrm_pkg::CNT_W'(DEPTH))
		else $error("held count above depth");

	// valid cells match the held count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(held_q))
		else $error("valid cells disagree with held count");

	// occupied cells form a contiguous run from cell zero
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("gap in valid cells");

	// a clear transfer leaves the queue empty with an empty result count
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && cmd == fwrm_pkg::CMD_CLEAR |=> held_q == '0 && rsp_count_q == '0)
		else $error("clear did not empty the queue");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for fifo_with_running_minimum
// Drives command transfers through the request channel and checks every
// result transfer against a queue-based prediction of status, data and
// count. A short directed pass covers empty, extreme and spare-code cases;
// random fill, drain and mixed bursts then push the queue to full and back.
// ----------------------------------------------------------------------------

module tb;

	// spare command codes, answered as min
	localparam logic [fwrm_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [fwrm_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam logic signed [fwrm_pkg::VAL_W-1:0] VAL_MAX =
		{1'b0, {(fwrm_pkg::VAL_W-1){1'b1}}};
	localparam logic signed [fwrm_pkg::VAL_W-1:0] VAL_MIN =
		{1'b1, {(fwrm_pkg::VAL_W-1){1'b0}}};

	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

	typedef struct {
		logic [fwrm_pkg::CMD_W-1:0]        cmd;
		logic signed [fwrm_pkg::VAL_W-1:0] value;
	} queue_cmd_t;

	typedef struct {
		fwrm_pkg::status_t                 status;
		logic signed [fwrm_pkg::VAL_W-1:0] data;
		logic [fwrm_pkg::COUNT_W-1:0]      count;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fwrm_req_if req_ch ();
	fwrm_rsp_if rsp_ch ();

	queue_cmd_t                        pending_cmds[$];
	queue_result_t                     awaited_results[$];
	logic signed [fwrm_pkg::VAL_W-1:0] held_values[$];

	int  items_total    = 0;
	int  items_accepted = 0;
	int  results_seen   = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  full_drops     = 0;
	int  empty_errors   = 0;
	int  min_reads      = 0;
	int  peak_held      = 0;
	bit  req_taken      = 1'b0;

	fifo_with_running_minimum DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line per mismatch, counted
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// queue an item for the driver
	task automatic add_cmd(input logic [fwrm_pkg::CMD_W-1:0] cmd,
			input logic signed [fwrm_pkg::VAL_W-1:0] value);
		queue_cmd_t c;
		c.cmd   = cmd;
		c.value = value;
		pending_cmds.push_back(c);
	endtask

	// operand mix: extremes, small values for ties, and full-width random
	function automatic logic signed [fwrm_pkg::VAL_W-1:0] pick_operand();
		logic signed [fwrm_pkg::VAL_W-1:0] v;
		case ($urandom_range(9))
			0: v = VAL_MIN;
			1: v = VAL_MAX;
			2: v = '0;
			3: v = '1;
			4, 5: begin
				v = $urandom_range(16);
				v = v - 8;
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// applies one command to the held values and returns its result
	function automatic queue_result_t predict_result(input logic [fwrm_pkg::CMD_W-1:0] cmd,
			input logic signed [fwrm_pkg::VAL_W-1:0] operand);
		queue_result_t r;
		logic signed [fwrm_pkg::VAL_W-1:0] lowest;
		r.status = fwrm_pkg::ST_OK;
		r.data   = '0;
		case (cmd)
			fwrm_pkg::CMD_ENQUEUE: begin
				if (held_values.size() >= fwrm_pkg::DEPTH) begin
					r.status = fwrm_pkg::ST_FULL;
					full_drops++;
				end else begin
					held_values.push_back(operand);
				end
			end
			fwrm_pkg::CMD_SIZE: ;
			fwrm_pkg::CMD_CLEAR: held_values.delete();
			default: begin
				if (held_values.size() == 0) begin
					r.status = fwrm_pkg::ST_EMPTY;
					empty_errors++;
				end else if (cmd == fwrm_pkg::CMD_FRONT) begin
					r.data = held_values[0];
				end else if (cmd == fwrm_pkg::CMD_DEQUEUE) begin
					r.data = held_values.pop_front();
				end else begin
					lowest = held_values[0];
					foreach (held_values[i])
						if (held_values[i] < lowest)
							lowest = held_values[i];
					r.data = lowest;
					min_reads++;
				end
			end
		endcase
		if (held_values.size() > peak_held)
			peak_held = held_values.size();
		r.count = fwrm_pkg::COUNT_W'(held_values.size());
		return r;
	endfunction

	// driver: request and result-ready change on the falling edge
	always @(negedge clk) begin
		int phase;
		int send_gap_pct;
		int sink_stall_pct;
		queue_cmd_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			// idling pattern moves through three phases over the run
			phase = (items_total == 0) ? 2 : (items_accepted * 3) / items_total;
			case (phase)
				0: begin
					send_gap_pct   = 30;
					sink_stall_pct = 61;
				end
				1: begin
					send_gap_pct   = 61;
					sink_stall_pct = 30;
				end
				default: begin
					send_gap_pct   = 0;
					sink_stall_pct = 0;
				end
			endcase
			// present a new item once the previous one has transferred
			if (!req_ch.valid || req_taken) begin
				req_taken = 1'b0;
				if (pending_cmds.size() == 0 || $urandom_range(99) < send_gap_pct) begin
					req_ch.valid <= 1'b0;
				end else begin
					nxt = pending_cmds.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd   <= nxt.cmd;
					req_ch.value <= nxt.value;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// monitor: predict on each request transfer, check each result transfer
	always @(posedge clk) begin
		queue_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("FAILURE");
			$finish;
		end else begin
			if (arst_n && req_ch.valid && req_ch.ready) begin
				awaited_results.push_back(predict_result(req_ch.cmd, req_ch.value));
				items_accepted++;
				req_taken = 1'b1;
			end
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing outstanding",
						results_seen));
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("result %0d status %0d, expected %0d",
							results_seen, rsp_ch.status, want.status));
					if (rsp_ch.data !== want.data)
						report_mismatch($sformatf("result %0d data %0d, expected %0d",
							results_seen, rsp_ch.data, want.data));
					if (rsp_ch.count !== want.count)
						report_mismatch($sformatf("result %0d count %0d, expected %0d",
							results_seen, rsp_ch.count, want.count));
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n_random;
		int seg_len;
		int roll;
		burst_t burst;
		logic [fwrm_pkg::CMD_W-1:0] side_cmd;

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = fwrm_pkg::CMD_SIZE;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;

		// directed: every read on an empty queue, extremes, spare codes, clear
		add_cmd(fwrm_pkg::CMD_DEQUEUE, VAL_MAX);
		add_cmd(fwrm_pkg::CMD_FRONT, VAL_MIN);
		add_cmd(fwrm_pkg::CMD_MIN, '0);
		add_cmd(CMD_SPARE_LO, '1);
		add_cmd(CMD_SPARE_HI, '0);
		add_cmd(fwrm_pkg::CMD_SIZE, '0);
		add_cmd(fwrm_pkg::CMD_ENQUEUE, VAL_MAX);
		add_cmd(fwrm_pkg::CMD_MIN, '0);
		add_cmd(fwrm_pkg::CMD_ENQUEUE, VAL_MIN);
		add_cmd(fwrm_pkg::CMD_ENQUEUE, '0);
		add_cmd(fwrm_pkg::CMD_ENQUEUE, '1);
		add_cmd(fwrm_pkg::CMD_FRONT, '0);
		add_cmd(fwrm_pkg::CMD_MIN, '0);
		add_cmd(CMD_SPARE_LO, '0);
		add_cmd(fwrm_pkg::CMD_DEQUEUE, '0);
		add_cmd(fwrm_pkg::CMD_DEQUEUE, '0);
		add_cmd(CMD_SPARE_HI, '0);
		add_cmd(fwrm_pkg::CMD_SIZE, VAL_MIN);
		add_cmd(fwrm_pkg::CMD_CLEAR, '0);
		add_cmd(fwrm_pkg::CMD_MIN, '0);
		add_cmd(fwrm_pkg::CMD_DEQUEUE, '0);
		add_cmd(fwrm_pkg::CMD_SIZE, '0);

		// random bursts; the first one fills
		n_random = 0;
		burst    = BURST_FILL;
		while (n_random < RANDOM_ITEMS) begin
			seg_len = $urandom_range(120, 40);
			for (int k = 0; k < seg_len; k++) begin
				roll = $urandom_range(99);
				case ($urandom_range(99))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17,
					18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29:
						side_cmd = fwrm_pkg::CMD_FRONT;
					default: begin
						if (roll < 30)       side_cmd = fwrm_pkg::CMD_MIN;
						else if (roll < 55)  side_cmd = fwrm_pkg::CMD_SIZE;
						else if (roll < 72)  side_cmd = CMD_SPARE_LO;
						else if (roll < 90)  side_cmd = CMD_SPARE_HI;
						else if (roll < 96)  side_cmd = fwrm_pkg::CMD_MIN;
						else                 side_cmd = fwrm_pkg::CMD_CLEAR;
					end
				endcase
				roll = $urandom_range(99);
				case (burst)
					BURST_FILL:
						if (roll < 85)
							add_cmd(fwrm_pkg::CMD_ENQUEUE, pick_operand());
						else if (roll < 92)
							add_cmd(fwrm_pkg::CMD_DEQUEUE, {$urandom, $urandom});
						else
							add_cmd(side_cmd, {$urandom, $urandom});
					BURST_DRAIN:
						if (roll < 15)
							add_cmd(fwrm_pkg::CMD_ENQUEUE, pick_operand());
						else if (roll < 80)
							add_cmd(fwrm_pkg::CMD_DEQUEUE, {$urandom, $urandom});
						else
							add_cmd(side_cmd, {$urandom, $urandom});
					default:
						if (roll < 45)
							add_cmd(fwrm_pkg::CMD_ENQUEUE, pick_operand());
						else if (roll < 75)
							add_cmd(fwrm_pkg::CMD_DEQUEUE, {$urandom, $urandom});
						else
							add_cmd(side_cmd, {$urandom, $urandom});
				endcase
				n_random++;
			end
			case ($urandom_range(2))
				0: burst = BURST_FILL;
				1: burst = BURST_DRAIN;
				default: burst = BURST_MIXED;
			endcase
		end
		items_total = pending_cmds.size();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every item to transfer and every result to come back
		while (items_accepted < items_total || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d commands, %0d results checked, peak depth %0d of %0d",
			items_total, results_seen, peak_held, fwrm_pkg::DEPTH);
		$display("full drops %0d, empty errors %0d, min reads %0d, mismatches %0d",
			full_drops, empty_errors, min_reads, mismatch_count);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
